[hw/rtl/quadratic_root_solver_core_assert.svh]
// Assertion macros shared by the solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define QRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while in reset.
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/qrs_pkg.sv]
`default_nettype none
package qrs_pkg;
   localparam int COEF_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF = 16;
   localparam int OUT_BITS      = 29;
   localparam int QUEUE_DEPTH   = 4;   // power of two

   localparam logic [1:0] KIND_REAL    = 2'd0;
   localparam logic [1:0] KIND_COMPLEX = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   typedef struct packed {
      logic err;         // leading coefficient zero
      logic disc_neg;    // complex roots
      logic center_neg;
      logic spread_neg;
   } flags_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } front_status_type;
endpackage
`default_nettype wire

[hw/rtl/qrs_front.sv]
`default_nettype none
module qrs_front #(
   parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic signed [COEF_BITS-1:0] coef_a,
   input  wire logic signed [COEF_BITS-1:0] coef_b,
   input  wire logic signed [COEF_BITS-1:0] coef_c,
   output logic                             push,
   output qrs_pkg::flags_type               flags,
   output logic [2*COEF_BITS+1:0]           abs_d,
   output logic [COEF_BITS:0]               denom,
   output logic [COEF_BITS-1:0]             abs_b,
   output qrs_pkg::front_status_type        status
);
   import qrs_pkg::*;

   localparam int DW = 2 * COEF_BITS + 2;

   logic                          s1_valid_ff;
   logic signed [COEF_BITS-1:0]   a_ff, b_ff, c_ff;

   logic                          s2_valid_ff;
   logic signed [2*COEF_BITS-1:0] bb_ff, ac_ff;
   logic                          a_zero_ff, a_neg_ff, center_neg_ff;
   logic [COEF_BITS-1:0]          abs_a_ff, abs_b_ff;

   logic signed [2*COEF_BITS-1:0] bb_in, ac_in;
   logic [COEF_BITS-1:0]          abs_a_in, abs_b_in;
   logic                          b_pos, center_neg_in;
   logic signed [DW-1:0]          disc;

   function automatic logic signed [2*COEF_BITS-1:0] coef_sq(
      input logic signed [COEF_BITS-1:0] v);
      coef_sq = v * v;
   endfunction

   // stage 2: products and signs
   always_comb begin
      bb_in         = coef_sq(b_ff);
      ac_in         = a_ff * c_ff;
      abs_a_in      = a_ff[COEF_BITS-1] ? COEF_BITS'(-a_ff) : COEF_BITS'(a_ff);
      abs_b_in      = b_ff[COEF_BITS-1] ? COEF_BITS'(-b_ff) : COEF_BITS'(b_ff);
      b_pos         = !b_ff[COEF_BITS-1] && (b_ff != '0);
      center_neg_in = (b_ff != '0) && (b_pos != a_ff[COEF_BITS-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      a_ff          <= coef_a;
      b_ff          <= coef_b;
      c_ff          <= coef_c;
      bb_ff         <= bb_in;
      ac_ff         <= ac_in;
      a_zero_ff     <= (a_ff == '0);
      a_neg_ff      <= a_ff[COEF_BITS-1];
      center_neg_ff <= center_neg_in;
      abs_a_ff      <= abs_a_in;
      abs_b_ff      <= abs_b_in;
   end

   // discriminant b*b - 4ac, exact
   always_comb begin
      disc             = DW'(bb_ff) - (DW'(ac_ff) <<< 2);
      push             = s2_valid_ff;
      flags.err        = a_zero_ff;
      flags.disc_neg   = disc[DW-1];
      flags.center_neg = center_neg_ff;
      flags.spread_neg = a_neg_ff;
      abs_d            = disc[DW-1] ? DW'(-disc) : DW'(disc);
      denom            = {abs_a_ff, 1'b0};
      abs_b            = abs_b_ff;
      status.s1_valid  = s1_valid_ff;
      status.s2_valid  = s2_valid_ff;
   end
endmodule
`default_nettype wire

[hw/rtl/qrs_queue.sv]
`default_nettype none
module qrs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic                            out_valid,
   output logic [WIDTH-1:0]                out_data,
   output logic [$clog2(DEPTH+1)-1:0]      count
);
   import qrs_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PW'(1);
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

`include "quadratic_root_solver_core_assert.svh"
   `QRS_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "queue overfilled")
   `QRS_ASSERT_IMP(a_q_push, clock, reset, push, (count_ff < CW'(DEPTH)) || pop, "push when full")
   `QRS_ASSERT_IMP(a_q_pop, clock, reset, pop, count_ff != '0, "pop when empty")
endmodule
`default_nettype wire

[hw/rtl/qrs_div.sv]
`default_nettype none
module qrs_div #(
   parameter int NUM_BITS = 29,
   parameter int DEN_BITS = 13
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [DEN_BITS-1:0] in_den,
   input  wire logic [NUM_BITS-1:0] in_num0,
   input  wire logic [NUM_BITS-1:0] in_num1,
   input  qrs_pkg::flags_type      in_flags,
   output logic                    out_valid,
   output logic [NUM_BITS-1:0]     out_quo0,
   output logic [NUM_BITS-1:0]     out_quo1,
   output qrs_pkg::flags_type      out_flags
);
   import qrs_pkg::*;

   // one quotient bit per stage, two numerators over a shared divisor
   logic                valid_ff [NUM_BITS];
   logic [DEN_BITS-1:0] den_ff   [NUM_BITS];
   logic [NUM_BITS-1:0] num0_ff  [NUM_BITS];
   logic [NUM_BITS-1:0] num1_ff  [NUM_BITS];
   logic [DEN_BITS-1:0] rem0_ff  [NUM_BITS];
   logic [DEN_BITS-1:0] rem1_ff  [NUM_BITS];
   logic [NUM_BITS-1:0] quo0_ff  [NUM_BITS];
   logic [NUM_BITS-1:0] quo1_ff  [NUM_BITS];
   flags_type           flags_ff [NUM_BITS];

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
      logic                valid_i;
      logic [DEN_BITS-1:0] den_i, rem0_i, rem1_i;
      logic [NUM_BITS-1:0] num0_i, num1_i, quo0_i, quo1_i;
      flags_type           flags_i;
      logic [DEN_BITS:0]   cur0, cur1;
      logic                ge0, ge1;

      if (k == 0) begin : g_first
         assign valid_i = in_valid;
         assign den_i   = in_den;
         assign num0_i  = in_num0;
         assign num1_i  = in_num1;
         assign rem0_i  = '0;
         assign rem1_i  = '0;
         assign quo0_i  = '0;
         assign quo1_i  = '0;
         assign flags_i = in_flags;
      end else begin : g_next
         assign valid_i = valid_ff[k-1];
         assign den_i   = den_ff[k-1];
         assign num0_i  = num0_ff[k-1];
         assign num1_i  = num1_ff[k-1];
         assign rem0_i  = rem0_ff[k-1];
         assign rem1_i  = rem1_ff[k-1];
         assign quo0_i  = quo0_ff[k-1];
         assign quo1_i  = quo1_ff[k-1];
         assign flags_i = flags_ff[k-1];
      end

      always_comb begin
         cur0 = {rem0_i, num0_i[NUM_BITS-1]};
         cur1 = {rem1_i, num1_i[NUM_BITS-1]};
         ge0  = cur0 >= {1'b0, den_i};
         ge1  = cur1 >= {1'b0, den_i};
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k] <= 1'b0;
         else       valid_ff[k] <= valid_i;
         den_ff[k]   <= den_i;
         flags_ff[k] <= flags_i;
         num0_ff[k]  <= num0_i << 1;
         num1_ff[k]  <= num1_i << 1;
         rem0_ff[k]  <= ge0 ? DEN_BITS'(cur0 - {1'b0, den_i}) : DEN_BITS'(cur0);
         rem1_ff[k]  <= ge1 ? DEN_BITS'(cur1 - {1'b0, den_i}) : DEN_BITS'(cur1);
         quo0_ff[k]  <= {quo0_i[NUM_BITS-2:0], ge0};
         quo1_ff[k]  <= {quo1_i[NUM_BITS-2:0], ge1};
      end
   end

   assign out_valid = valid_ff[NUM_BITS-1];
   assign out_quo0  = quo0_ff[NUM_BITS-1];
   assign out_quo1  = quo1_ff[NUM_BITS-1];
   assign out_flags = flags_ff[NUM_BITS-1];
endmodule
`default_nettype wire

[hw/rtl/qrs_back.sv]
`default_nettype none
module qrs_back #(
   parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  qrs_pkg::flags_type             in_flags,
   input  wire logic [2*COEF_BITS+1:0]    in_abs_d,
   input  wire logic [COEF_BITS:0]        in_denom,
   input  wire logic [COEF_BITS-1:0]      in_abs_b,
   output logic                           out_valid,
   output logic [1:0]                     out_kind,
   output logic signed [qrs_pkg::OUT_BITS-1:0] out_center,
   output logic signed [qrs_pkg::OUT_BITS-1:0] out_spread
);
   import qrs_pkg::*;

   localparam int PAIRS = COEF_BITS + 1;
   localparam int DB    = 2 * PAIRS;
   localparam int R     = PAIRS + FRAC_BITS;      // root bits, sqrt stages
   localparam int RW    = R + 2;                  // remainder width
   localparam int DENW  = COEF_BITS + 1;
   localparam int MW    = ((R > OUT_BITS) ? R : OUT_BITS) + 1;
   localparam logic [MW-1:0] LIM_POS = MW'((64'd1 << (OUT_BITS - 1)) - 64'd1);
   localparam logic [MW-1:0] LIM_NEG = MW'(64'd1 << (OUT_BITS - 1));

   // square root: one result bit per stage
   logic                 sv_ff    [R];
   logic [RW-1:0]        srem_ff  [R];
   logic [R-1:0]         sroot_ff [R];
   logic [DB-1:0]        srad_ff  [R];
   logic [DENW-1:0]      sden_ff  [R];
   logic [COEF_BITS-1:0] sabsb_ff [R];
   flags_type            sflg_ff  [R];

   for (genvar k = 0; k < R; k++) begin : g_sq
      logic                 v_i;
      logic [RW-1:0]        rem_i;
      logic [R-1:0]         root_i;
      logic [DB-1:0]        rad_i;
      logic [DENW-1:0]      den_i;
      logic [COEF_BITS-1:0] absb_i;
      flags_type            flg_i;
      logic [1:0]           pair;
      logic [RW+1:0]        cur, trial;
      logic                 ge;

      if (k == 0) begin : g_first
         assign v_i    = in_valid;
         assign rem_i  = '0;
         assign root_i = '0;
         assign rad_i  = in_abs_d;
         assign den_i  = in_denom;
         assign absb_i = in_abs_b;
         assign flg_i  = in_flags;
      end else begin : g_next
         assign v_i    = sv_ff[k-1];
         assign rem_i  = srem_ff[k-1];
         assign root_i = sroot_ff[k-1];
         assign rad_i  = srad_ff[k-1];
         assign den_i  = sden_ff[k-1];
         assign absb_i = sabsb_ff[k-1];
         assign flg_i  = sflg_ff[k-1];
      end

      if (k < PAIRS) begin : g_pair
         assign pair = rad_i[DB-1 -: 2];
      end else begin : g_frac
         assign pair = 2'b00;
      end

      always_comb begin
         cur   = {rem_i, pair};
         trial = (RW+2)'({root_i, 2'b01});
         ge    = cur >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) sv_ff[k] <= 1'b0;
         else       sv_ff[k] <= v_i;
         srem_ff[k]  <= ge ? RW'(cur - trial) : RW'(cur);
         sroot_ff[k] <= {root_i[R-2:0], ge};
         srad_ff[k]  <= rad_i << 2;
         sden_ff[k]  <= den_i;
         sabsb_ff[k] <= absb_i;
         sflg_ff[k]  <= flg_i;
      end
   end

   logic [R-1:0] center_num;
   logic         dv;
   logic [R-1:0] q_spread, q_center;
   flags_type    dflags;

   assign center_num = R'({sabsb_ff[R-1], {FRAC_BITS{1'b0}}});

   qrs_div #(
      .NUM_BITS (R),
      .DEN_BITS (DENW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sv_ff[R-1]),
      .in_den    (sden_ff[R-1]),
      .in_num0   (sroot_ff[R-1]),
      .in_num1   (center_num),
      .in_flags  (sflg_ff[R-1]),
      .out_valid (dv),
      .out_quo0  (q_spread),
      .out_quo1  (q_center),
      .out_flags (dflags)
   );

   function automatic logic [OUT_BITS-1:0] sat_sign(input logic [R-1:0] mag,
                                                   input logic neg);
      logic [MW-1:0] m;
      m = MW'(mag);
      if (neg) sat_sign = (m > LIM_NEG) ? OUT_BITS'(LIM_NEG) : OUT_BITS'(-m);
      else     sat_sign = (m > LIM_POS) ? OUT_BITS'(LIM_POS) : OUT_BITS'(m);
   endfunction

   logic                valid_ff;
   logic [1:0]          kind_ff, kind_in;
   logic [OUT_BITS-1:0] center_ff, spread_ff, center_in, spread_in;

   always_comb begin
      if (dflags.err) begin
         kind_in   = KIND_ERROR;
         center_in = '0;
         spread_in = '0;
      end else begin
         kind_in   = dflags.disc_neg ? KIND_COMPLEX : KIND_REAL;
         center_in = sat_sign(q_center, dflags.center_neg);
         spread_in = sat_sign(q_spread, dflags.spread_neg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= dv;
      kind_ff   <= kind_in;
      center_ff <= center_in;
      spread_ff <= spread_in;
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_center = signed'(center_ff);
   assign out_spread = signed'(spread_ff);
endmodule
`default_nettype wire

[hw/rtl/quadratic_root_solver_core.sv]
// Quadratic root solver: roots of a*x^2 + b*x + c for signed integer coefficients.
// Input: drive req_coef_square/linear/constant and raise start; the word is taken
//   at a clock edge where start is high and busy is low.
// Output: one result word per input, shown for exactly one cycle with rsp_valid.
//   rsp_root_kind: 0 real, 1 complex, 2 leading coefficient zero (fields then 0).
//   rsp_root_center = -b/(2a), rsp_root_spread = sqrt(|b*b-4ac|)/(2a), both signed
//   with FRAC_BITS fraction bits, truncated toward zero, saturated to 29 bits.
// Throughput: one word per cycle, fully pipelined.
// Path from accept to rsp_valid: front-end registers, queue, the bit-per-stage square
//   root and divider pipelines, then the output register.
// Structure: front end registers the word and forms the exact discriminant, a
//   four-word queue decouples it from the back end (square root, then division).
// busy only rises if the queue could overflow; the back end never stalls, so
//   it stays low in normal use. The receiver cannot hold results off.
// Reset clears all valid flags; no words are in flight afterwards.
`default_nettype none
module quadratic_root_solver_core #(
   parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic signed [COEF_BITS-1:0]    req_coef_square,
   input  wire logic signed [COEF_BITS-1:0]    req_coef_linear,
   input  wire logic signed [COEF_BITS-1:0]    req_coef_constant,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_root_kind,
   output logic signed [qrs_pkg::OUT_BITS-1:0] rsp_root_center,
   output logic signed [qrs_pkg::OUT_BITS-1:0] rsp_root_spread
);
   import qrs_pkg::*;

   localparam int DB  = 2 * COEF_BITS + 2;
   localparam int FW  = $bits(flags_type);
   localparam int QW  = FW + DB + (COEF_BITS + 1) + COEF_BITS;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);

   logic                   accept;
   logic                   f_push;
   flags_type              f_flags, b_flags;
   logic [DB-1:0]          f_abs_d, b_abs_d;
   logic [COEF_BITS:0]     f_denom, b_denom;
   logic [COEF_BITS-1:0]   f_abs_b, b_abs_b;
   front_status_type       f_status;
   logic                   q_valid;
   logic [QW-1:0]          q_data;
   logic [CW-1:0]          q_count;

   assign accept = start && !busy;

   // words in queue plus words still in the front end must fit the queue
   assign busy = ((CW+1)'(q_count) + (CW+1)'(f_status.s1_valid)
                  + (CW+1)'(f_status.s2_valid)) >= (CW+1)'(QUEUE_DEPTH);

   qrs_front #(
      .COEF_BITS (COEF_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .coef_a (req_coef_square),
      .coef_b (req_coef_linear),
      .coef_c (req_coef_constant),
      .push   (f_push),
      .flags  (f_flags),
      .abs_d  (f_abs_d),
      .denom  (f_denom),
      .abs_b  (f_abs_b),
      .status (f_status)
   );

   qrs_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_flags, f_abs_d, f_denom, f_abs_b}),
      .pop       (q_valid),           // back end always takes a word
      .out_valid (q_valid),
      .out_data  (q_data),
      .count     (q_count)
   );

   assign {b_flags, b_abs_d, b_denom, b_abs_b} = q_data;

   qrs_back #(
      .COEF_BITS (COEF_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_flags   (b_flags),
      .in_abs_d   (b_abs_d),
      .in_denom   (b_denom),
      .in_abs_b   (b_abs_b),
      .out_valid  (rsp_valid),
      .out_kind   (rsp_root_kind),
      .out_center (rsp_root_center),
      .out_spread (rsp_root_spread)
   );

`include "quadratic_root_solver_core_assert.svh"
   `QRS_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && (rsp_root_kind == KIND_ERROR), (rsp_root_center == '0) && (rsp_root_spread == '0), "error word not zeroed")
   `QRS_ASSERT_IMP(a_kind_ok, clock, reset, rsp_valid, (rsp_root_kind == KIND_REAL) || (rsp_root_kind == KIND_COMPLEX) || (rsp_root_kind == KIND_ERROR), "bad root kind")
   `QRS_ASSERT_NEXT(a_accept_in, clock, reset, accept, f_status.s1_valid, "accepted word lost")
endmodule
`default_nettype wire

[tb/quadratic_root_solver_core_test.sv]
`default_nettype none
module quadratic_root_solver_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import qrs_pkg::*;

   localparam int CB = COEF_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int OB = OUT_BITS;
   localparam int N_RANDOM = 1800;
   localparam int STALL_LIMIT = 2000;   // quiet cycles before giving up
   localparam int DRAIN_CYCLES = 80;    // idle wait after the last expected result

   typedef struct {
      logic signed [CB-1:0] a;
      logic signed [CB-1:0] b;
      logic signed [CB-1:0] c;
   } coef_word_type;

   typedef struct {
      logic [1:0]           kind;
      logic signed [OB-1:0] center;
      logic signed [OB-1:0] spread;
   } roots_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CB-1:0] req_coef_square = '0;
   logic signed [CB-1:0] req_coef_linear = '0;
   logic signed [CB-1:0] req_coef_constant = '0;
   logic rsp_valid;
   logic [1:0] rsp_root_kind;
   logic signed [OB-1:0] rsp_root_center;
   logic signed [OB-1:0] rsp_root_spread;

   coef_word_type  coef_queue[$];
   roots_word_type roots_expected[$];
   int             mismatch_count = 0;
   int             quiet_cycles = 0;
   int             gap_left = 0;

   quadratic_root_solver_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_square(req_coef_square), .req_coef_linear(req_coef_linear),
      .req_coef_constant(req_coef_constant), .rsp_valid(rsp_valid),
      .rsp_root_kind(rsp_root_kind), .rsp_root_center(rsp_root_center),
      .rsp_root_spread(rsp_root_spread)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor(sqrt(d * 4^FB)), digit by digit, two bits of radicand per step
   function automatic longint unsigned isqrt_scaled(longint unsigned d);
      longint unsigned rad, rem, root, trial;
      rad = d << (2 * FB);
      rem = 0;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         rem = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic signed [OB-1:0] signed_sat(longint unsigned mag, bit neg);
      longint lim;
      lim = (64'sd1 <<< (OB - 1));
      if (neg) return OB'((mag > lim) ? -lim : -longint'(mag));
      return OB'((mag > lim - 1) ? lim - 1 : longint'(mag));
   endfunction

   function automatic roots_word_type solve_roots(coef_word_type w);
      roots_word_type r;
      longint a, b, c, disc;
      longint unsigned abs_b, abs_d, denom;
      a = w.a;
      b = w.b;
      c = w.c;
      if (a == 0) begin
         r.kind = KIND_ERROR;
         r.center = '0;
         r.spread = '0;
         return r;
      end
      disc = b * b - 4 * a * c;
      abs_b = (b < 0) ? -b : b;
      abs_d = (disc < 0) ? -disc : disc;
      denom = 2 * ((a < 0) ? -a : a);
      r.kind = (disc < 0) ? KIND_COMPLEX : KIND_REAL;
      // -b/(2a) is negative when a and b share a strict sign
      r.center = signed_sat((abs_b << FB) / denom, (b != 0) && ((b > 0) != (a < 0)));
      r.spread = signed_sat(isqrt_scaled(abs_d) / denom, a < 0);
      return r;
   endfunction

   function automatic coef_word_type mk(int a, int b, int c);
      coef_word_type w;
      w.a = CB'(a);
      w.b = CB'(b);
      w.c = CB'(c);
      return w;
   endfunction

   function automatic logic signed [CB-1:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return CB'($urandom_range(0, 1) ? -(2 ** (CB - 1)) : 2 ** (CB - 1) - 1);
         1: return CB'(int'($urandom_range(0, 6)) - 3);
         default: return CB'($urandom());
      endcase
   endfunction

   // Driver: pops a word, holds start until accepted, then waits a random gap.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         roots_expected.push_back(solve_roots(mk(req_coef_square, req_coef_linear,
                                                 req_coef_constant)));
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
         if (gap_left == 0 && coef_queue.size() > 0) begin
            coef_word_type w;
            w = coef_queue.pop_front();
            req_coef_square <= w.a;
            req_coef_linear <= w.b;
            req_coef_constant <= w.c;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (coef_queue.size() > 0) begin
            coef_word_type w;
            w = coef_queue.pop_front();
            req_coef_square <= w.a;
            req_coef_linear <= w.b;
            req_coef_constant <= w.c;
            start <= 1'b1;
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (roots_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: kind=%0d center=%0d spread=%0d",
                        rsp_root_kind, rsp_root_center, rsp_root_spread);
         end else begin
            roots_word_type e;
            e = roots_expected.pop_front();
            if (e.kind !== rsp_root_kind || e.center !== rsp_root_center ||
                e.spread !== rsp_root_spread) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp kind=%0d center=%0d spread=%0d, got %0d %0d %0d",
                           e.kind, e.center, e.spread, rsp_root_kind,
                           rsp_root_center, rsp_root_spread);
            end
         end
      end
   end

   // Watchdog: counts cycles in which no word moves either way.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int mx, mn;
      mx = 2 ** (CB - 1) - 1;
      mn = -(2 ** (CB - 1));
      // directed: leading zero, zero/neg/pos discriminant, extremes, sign mixes
      coef_queue.push_back(mk(0, 5, 7));
      coef_queue.push_back(mk(0, mn, mx));
      coef_queue.push_back(mk(0, 0, 0));
      coef_queue.push_back(mk(1, 2, 1));
      coef_queue.push_back(mk(-1, 2, -1));
      coef_queue.push_back(mk(1, 0, 1));
      coef_queue.push_back(mk(1, 0, -4));
      coef_queue.push_back(mk(-3, 7, 5));
      coef_queue.push_back(mk(2, -7, 5));
      coef_queue.push_back(mk(mx, mx, mx));
      coef_queue.push_back(mk(mn, mn, mn));
      coef_queue.push_back(mk(mx, mn, mn));
      coef_queue.push_back(mk(mn, mx, mn));
      coef_queue.push_back(mk(mn, mn, mx));
      coef_queue.push_back(mk(mx, 0, mn));
      coef_queue.push_back(mk(1, mn, mn));
      coef_queue.push_back(mk(1, mx, mn));
      coef_queue.push_back(mk(-1, mn, mx));
      coef_queue.push_back(mk(mn, 0, 0));
      coef_queue.push_back(mk(1, 0, 0));
      coef_queue.push_back(mk(-1, -1, -1));
      coef_queue.push_back(mk(3, 0, mx));
      for (int i = 0; i < N_RANDOM; i++) begin
         coef_word_type w;
         w.a = ($urandom_range(0, 15) == 0) ? '0 : rand_coef();
         w.b = rand_coef();
         w.c = rand_coef();
         coef_queue.push_back(w);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (coef_queue.size() == 0 && !start);
      wait (roots_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && roots_expected.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
